### rtl/weg_pkg.sv
// ---------------------------------------------------------------------------
// weg_pkg - shared types and constants for the windowed energy gather
// Request/response payloads, register indexes, codes and the divider bundle.
// ---------------------------------------------------------------------------
package weg_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SQ_W        = 2 * SAMPLE_BITS;   // one squared sample
  localparam int E_W         = 48;                // energy word
  localparam int CFG_W       = 11;                // widest register
  localparam int CFG_IDX_W   = 3;
  localparam int POS_W       = 23;                // window start / end positions
  localparam int IDX_W       = 19;                // trace base plus window index
  localparam int TRACE_CAP   = 64;                // most traces in one gather
  localparam int STEP_W      = 6;                 // divider step count
  localparam int DIV_STEPS_FULL = 48;
  localparam int DIV_STEPS_FRAC = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WLEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WSTEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOWS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORM     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE  = 3'd6;

  // request opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // response status
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  typedef struct packed {
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] sample;
  } weg_req_t;

  typedef struct packed {
    logic [E_W-1:0] energy;
    logic           last_of_gather;
    logic           status;
  } weg_rsp_t;

  // shared divider command and result
  typedef struct packed {
    logic              start;
    logic [E_W-1:0]    rem_init;
    logic [E_W-1:0]    dividend;
    logic [E_W-1:0]    divisor;
    logic [STEP_W-1:0] steps;
  } weg_div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [E_W-1:0] quotient;
  } weg_div_rsp_t;

endpackage

### rtl/weg_div.sv
// ---------------------------------------------------------------------------
// weg_div - shared restoring divider
// One quotient bit per cycle. The partial remainder starts at rem_init and the
// dividend bits shift in MSB first, so the unit serves integer division
// (rem_init zero) as well as fractional division (dividend zero).
// ---------------------------------------------------------------------------
module weg_div
  import weg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  weg_div_req_t req,
  output weg_div_rsp_t rsp
);

  logic [E_W-1:0]    rem;
  logic [E_W-1:0]    dvd;
  logic [E_W-1:0]    dvs;
  logic [E_W-1:0]    quo;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [E_W:0]   trial;
  logic [E_W+1:0] diff;
  logic           ge;

  // one trial subtract per step
  always_comb begin
    trial = {rem, dvd[E_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvs};
    ge    = ~diff[E_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= req.rem_init;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        quo  <= '0;
        cnt  <= req.steps;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[E_W-1:0] : trial[E_W-1:0];
        dvd <= {dvd[E_W-2:0], 1'b0};
        quo <= {quo[E_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### rtl/windowed_energy_gather.sv
// Short-time energy of a gather of traces. On a push request the block stays
// ready, except that the final sample of a trace starts the window pass: per
// window a setup step, a square memory read and an accumulate step per summed
// sample, a done step, a division with averaging on (one bit a cycle in the
// single shared divider) and a write step. A read request passes the cap, data
// and output steps, plus a division when normalizing to the peak and one when
// the trace count has to be capped by the number of windows. A response waits
// in its own register, so the next request is taken while it is pending. Both
// stores start undefined and need no clearing after reset.
// ---------------------------------------------------------------------------
// windowed_energy_gather - windowed energy of a gather, top level
// Square store, window sequencer, energy store, peak tracking and read-out.
// ---------------------------------------------------------------------------
module windowed_energy_gather
  import weg_pkg::*;
#(
  parameter int MAX_TRACE   = 1024,
  parameter int MAX_OUTPUTS = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  weg_req_t             req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output weg_rsp_t             rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SQ_AW = $clog2(MAX_TRACE);
  localparam int SC_W  = $clog2(MAX_TRACE) + 1;
  localparam int EA_W  = $clog2(MAX_OUTPUTS);
  localparam int TC_W  = 7;
  localparam int TOT_W = 18;

  typedef enum logic [3:0] {
    S_IDLE, S_FIN_START, S_WIN_SETUP, S_WIN_RD, S_WIN_ACC, S_WIN_DONE,
    S_WIN_DIV, S_WIN_WR, S_CAP, S_CAP_WAIT, S_CAP_USE, S_RD_DATA,
    S_RD_DIV, S_OUT
  } state_t;

  // configuration
  logic [CFG_W-1:0] spt, wlen, wstep, wpt;
  logic [TC_W-1:0]  tpg;
  logic             norm, avg;

  // control and working registers
  state_t           state;
  logic [SC_W-1:0]  sc;
  logic [TC_W-1:0]  tc;
  logic [E_W-1:0]   peak;
  logic [EA_W-1:0]  rp;
  logic             gready;
  logic [TC_W-1:0]  eff;
  logic             rd_mode;
  logic [CFG_W-1:0] w;
  logic [POS_W-1:0] wstart, wend, pos;
  logic [E_W-1:0]   sum;
  logic [IDX_W-1:0] widx;
  logic [E_W-1:0]   e_val;
  logic             last_r, stat_r;

  // memories
  logic [SQ_W-1:0] sq_mem [MAX_TRACE];
  logic [E_W-1:0]  en_mem [MAX_OUTPUTS];
  logic [SQ_W-1:0] sq_q;
  logic [E_W-1:0]  en_q;

  weg_div_req_t div_req;
  weg_div_rsp_t div_rsp;

  // effective register values
  logic [CFG_W-1:0] n_eff, len_eff, nw_eff;
  logic [TC_W-1:0]  t_clamp;
  logic [TOT_W-1:0] t_prod, total;
  logic             fits;

  always_comb begin
    if (spt == '0)                          n_eff = CFG_W'(1);
    else if (32'(spt) > 32'(MAX_TRACE))     n_eff = CFG_W'(MAX_TRACE);
    else                                    n_eff = spt;
    len_eff = (wlen == '0) ? CFG_W'(1) : wlen;
    if (wpt == '0)                          nw_eff = CFG_W'(1);
    else if (32'(wpt) > 32'(MAX_OUTPUTS))   nw_eff = CFG_W'(MAX_OUTPUTS);
    else                                    nw_eff = wpt;
    if (tpg == '0)                          t_clamp = TC_W'(1);
    else if (32'(tpg) > 32'(TRACE_CAP))     t_clamp = TC_W'(TRACE_CAP);
    else                                    t_clamp = tpg;
    t_prod = TOT_W'(t_clamp) * TOT_W'(nw_eff);
    fits   = 32'(t_prod) <= 32'(MAX_OUTPUTS);
    total  = TOT_W'(eff) * TOT_W'(nw_eff);
  end

  // push datapath: magnitude and square
  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_W-1:0]        sq_wdata;
  logic                   accept, sq_we, en_we;
  logic [SC_W-1:0]        sc_next;

  always_comb begin
    mag      = req.sample[SAMPLE_BITS-1] ? (~req.sample + 1'b1) : req.sample;
    sq_wdata = SQ_W'(mag) * SQ_W'(mag);
    accept   = req_valid && req_ready;
    sq_we    = accept && (req.opcode == OP_PUSH) && !gready &&
               (32'(sc) < 32'(MAX_TRACE));
    sc_next  = sc + 1'b1;
    en_we    = (state == S_WIN_WR) && (32'(widx) < 32'(MAX_OUTPUTS));
  end

  assign req_ready = (state == S_IDLE);

  // window end, clipped at the trace end
  logic [POS_W-1:0] end_c;
  logic [E_W:0]     acc_sum;

  always_comb begin
    end_c   = ((wstart + POS_W'(len_eff)) > POS_W'(n_eff)) ? POS_W'(n_eff)
                                                          : wstart + POS_W'(len_eff);
    acc_sum = {1'b0, sum} + (E_W+1)'(sq_q);
  end

  // divider commands
  always_comb begin
    div_req = '0;
    case (state)
      S_CAP: begin
        if (!fits) begin
          div_req.start    = 1'b1;
          div_req.dividend = E_W'(MAX_OUTPUTS);
          div_req.divisor  = E_W'(nw_eff);
          div_req.steps    = STEP_W'(DIV_STEPS_FULL);
        end
      end
      S_WIN_DONE: begin
        if (avg) begin
          div_req.start    = 1'b1;
          div_req.dividend = sum;
          div_req.divisor  = E_W'(len_eff);
          div_req.steps    = STEP_W'(DIV_STEPS_FULL);
        end
      end
      S_RD_DATA: begin
        if (norm && (peak != '0) && (en_q < peak)) begin
          div_req.start    = 1'b1;
          div_req.rem_init = en_q;
          div_req.divisor  = peak;
          div_req.steps    = STEP_W'(DIV_STEPS_FRAC);
        end
      end
      default: ;
    endcase
  end

  weg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // square store
  always_ff @(posedge clk) begin
    if (sq_we) sq_mem[sc[SQ_AW-1:0]] <= sq_wdata;
    sq_q <= sq_mem[pos[SQ_AW-1:0]];
  end

  // energy store
  always_ff @(posedge clk) begin
    if (en_we) en_mem[widx[EA_W-1:0]] <= sum;
    en_q <= en_mem[rp];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      spt   <= CFG_W'(1024);
      tpg   <= TC_W'(4);
      wlen  <= CFG_W'(16);
      wstep <= CFG_W'(8);
      wpt   <= CFG_W'(128);
      norm  <= 1'b0;
      avg   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLES: spt   <= cfg_data;
        REG_TRACES:  tpg   <= cfg_data[TC_W-1:0];
        REG_WLEN:    wlen  <= cfg_data;
        REG_WSTEP:   wstep <= cfg_data;
        REG_WINDOWS: wpt   <= cfg_data;
        REG_NORM:    norm  <= cfg_data[0];
        REG_AVERAGE: avg   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sc        <= '0;
      tc        <= '0;
      peak      <= '0;
      rp        <= '0;
      gready    <= 1'b0;
      rsp_valid <= 1'b0;
      rd_mode   <= 1'b0;
    end else begin
      // response taken; S_OUT reloads it itself
      if (rsp_valid && rsp_ready && (state != S_OUT)) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.opcode == OP_READ) begin
              if (gready) begin
                rd_mode <= 1'b1;
                state   <= S_CAP;
              end else begin
                e_val  <= '0;
                last_r <= 1'b0;
                stat_r <= ST_EMPTY;
                state  <= S_OUT;
              end
            end else if (!gready) begin
              sc <= sc_next;
              if (32'(sc_next) >= 32'(n_eff)) state <= S_FIN_START;
            end
          end
        end
        S_FIN_START: begin
          w      <= '0;
          wstart <= '0;
          widx   <= IDX_W'(TOT_W'(tc) * TOT_W'(nw_eff));
          state  <= S_WIN_SETUP;
        end
        S_WIN_SETUP: begin
          wend  <= end_c;
          pos   <= wstart;
          sum   <= '0;
          state <= (wstart < end_c) ? S_WIN_RD : S_WIN_DONE;
        end
        S_WIN_RD: begin
          pos   <= pos + 1'b1;
          state <= S_WIN_ACC;
        end
        S_WIN_ACC: begin
          sum   <= acc_sum[E_W] ? {E_W{1'b1}} : acc_sum[E_W-1:0];
          state <= (pos < wend) ? S_WIN_RD : S_WIN_DONE;
        end
        S_WIN_DONE: begin
          state <= avg ? S_WIN_DIV : S_WIN_WR;
        end
        S_WIN_DIV: begin
          if (div_rsp.done) begin
            sum   <= div_rsp.quotient;
            state <= S_WIN_WR;
          end
        end
        S_WIN_WR: begin
          if (sum > peak) peak <= sum;
          w      <= w + 1'b1;
          wstart <= wstart + POS_W'(wstep);
          widx   <= widx + 1'b1;
          if (32'(w) + 32'd1 >= 32'(nw_eff)) begin
            tc      <= tc + 1'b1;
            sc      <= '0;
            rd_mode <= 1'b0;
            state   <= S_CAP;
          end else begin
            state <= S_WIN_SETUP;
          end
        end
        // traces per gather, capped so that all windows fit the store
        S_CAP: begin
          if (fits) begin
            eff   <= t_clamp;
            state <= S_CAP_USE;
          end else begin
            state <= S_CAP_WAIT;
          end
        end
        S_CAP_WAIT: begin
          if (div_rsp.done) begin
            eff   <= (div_rsp.quotient > E_W'(TRACE_CAP)) ? TC_W'(TRACE_CAP)
                                                          : div_rsp.quotient[TC_W-1:0];
            state <= S_CAP_USE;
          end
        end
        S_CAP_USE: begin
          if (rd_mode) begin
            state <= S_RD_DATA;
          end else begin
            if (32'(tc) >= 32'(eff)) begin
              gready <= 1'b1;
              rp     <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_RD_DATA: begin
          last_r <= (32'(rp) + 32'd1) >= 32'(total);
          stat_r <= ST_OK;
          if (norm && (peak != '0)) begin
            if (en_q >= peak) begin
              e_val <= E_W'(16'hFFFF);
              state <= S_OUT;
            end else begin
              state <= S_RD_DIV;
            end
          end else begin
            e_val <= en_q;
            state <= S_OUT;
          end
        end
        S_RD_DIV: begin
          if (div_rsp.done) begin
            e_val <= E_W'(div_rsp.quotient[DIV_STEPS_FRAC-1:0]);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid          <= 1'b1;
            rsp.energy         <= e_val;
            rsp.last_of_gather <= last_r;
            rsp.status         <= stat_r;
            if (stat_r == ST_OK) begin
              if (last_r) begin
                gready <= 1'b0;
                rp     <= '0;
                tc     <= '0;
                sc     <= '0;
                peak   <= '0;
              end else begin
                rp <= rp + 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_empty_rsp_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_EMPTY) |-> (rsp.energy == '0 && !rsp.last_of_gather))
    else $error("empty response carries data");

  a_trace_count_cap: assert property (@(posedge clk) disable iff (rst)
    32'(tc) <= 32'(TRACE_CAP))
    else $error("trace count beyond gather limit");

  a_ready_gather_push: assert property (@(posedge clk) disable iff (rst)
    (accept && req.opcode == OP_PUSH && gready) |=> (state == S_IDLE && $stable(sc)))
    else $error("push taken while a gather waits for read-out");

endmodule

### test/weg_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// weg_checker - response checker for the windowed energy gather
// Watches the request, response and register channels, keeps its own copy of
// the squares, the window energies and the peak, and compares every response
// field by field with the oldest predicted one.
// ---------------------------------------------------------------------------
module weg_checker
  import weg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  weg_req_t             req,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  weg_rsp_t             rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   outstanding
);

  localparam int unsigned TRACE_DEPTH  = 1024;
  localparam int unsigned ENERGY_DEPTH = 4096;
  localparam longint unsigned SAT48    = 64'hFFFF_FFFF_FFFF;

  // register copies
  logic [10:0] n_samples, win_len, win_step, n_windows;
  logic [6:0]  n_traces;
  logic        norm_on, avg_on;

  // gather state
  longint unsigned squares[TRACE_DEPTH];
  longint unsigned energies[ENERGY_DEPTH];
  int unsigned     fill_count, traces_done, read_idx;
  longint unsigned peak;
  bit              gather_full;

  weg_rsp_t readout_q[$];

  function automatic int unsigned eff_samples();
    if (n_samples < 1) return 1;
    if (n_samples > TRACE_DEPTH) return TRACE_DEPTH;
    return n_samples;
  endfunction

  function automatic int unsigned eff_len();
    return (win_len < 1) ? 1 : win_len;
  endfunction

  function automatic int unsigned eff_windows();
    return (n_windows < 1) ? 1 : n_windows;
  endfunction

  function automatic int unsigned eff_traces();
    int unsigned cap;
    cap = ENERGY_DEPTH / eff_windows();
    if (cap > 64) cap = 64;
    if (cap < 1) cap = 1;
    if (n_traces < 1) return 1;
    if (n_traces > cap) return cap;
    return n_traces;
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < 30) $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  // window sums for the trace just completed
  task automatic close_trace();
    longint unsigned n, len, nw, start, sum, i, idx;
    n   = eff_samples();
    len = eff_len();
    nw  = eff_windows();
    for (longint unsigned w = 0; w < nw; w++) begin
      start = w * win_step;
      sum   = 0;
      for (i = start; i < start + len && i < n; i++) begin
        sum += squares[i];
        if (sum > SAT48) sum = SAT48;
      end
      if (avg_on) sum /= len;
      idx = traces_done * nw + w;
      if (idx < ENERGY_DEPTH) energies[idx] = sum;
      if (sum > peak) peak = sum;
    end
    fill_count = 0;
    traces_done++;
    if (traces_done >= eff_traces()) begin
      gather_full = 1;
      read_idx    = 0;
    end
  endtask

  // work out the response (if any) for one accepted request
  task automatic model_request(weg_req_t r);
    longint          s;
    longint unsigned e;
    weg_rsp_t        exp_rsp;
    bit              last;
    if (r.opcode == OP_PUSH) begin
      if (gather_full) return;
      s = r.sample;
      if (fill_count < TRACE_DEPTH) squares[fill_count] = (s < 0 ? -s : s) * (s < 0 ? -s : s);
      fill_count++;
      if (fill_count >= eff_samples()) close_trace();
      return;
    end
    if (!gather_full) begin
      exp_rsp = '{energy: '0, last_of_gather: 1'b0, status: ST_EMPTY};
      readout_q.push_back(exp_rsp);
      return;
    end
    e = (read_idx < ENERGY_DEPTH) ? energies[read_idx] : 0;
    if (norm_on && peak != 0) begin
      e = (e << 16) / peak;
      if (e > 64'hFFFF) e = 64'hFFFF;
    end
    last = (read_idx + 1 >= eff_traces() * eff_windows());
    exp_rsp = '{energy: e[E_W-1:0], last_of_gather: last, status: ST_OK};
    readout_q.push_back(exp_rsp);
    if (last) begin
      gather_full = 0;
      read_idx    = 0;
      traces_done = 0;
      fill_count  = 0;
      peak        = 0;
    end else begin
      read_idx++;
    end
  endtask

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    weg_rsp_t want;
    if (rst) begin
      n_samples   = 11'd1024;
      n_traces    = 7'd4;
      win_len     = 11'd16;
      win_step    = 11'd8;
      n_windows   = 11'd128;
      norm_on     = 0;
      avg_on      = 0;
      fill_count  = 0;
      traces_done = 0;
      read_idx    = 0;
      peak        = 0;
      gather_full = 0;
      readout_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLES: n_samples = cfg_data;
          REG_TRACES:  n_traces  = cfg_data[6:0];
          REG_WLEN:    win_len   = cfg_data;
          REG_WSTEP:   win_step  = cfg_data;
          REG_WINDOWS: n_windows = cfg_data;
          REG_NORM:    norm_on   = cfg_data[0];
          REG_AVERAGE: avg_on    = cfg_data[0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) model_request(req);
      // response compare
      if (rsp_valid && rsp_ready) begin
        if (readout_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = readout_q.pop_front();
          if (rsp.energy !== want.energy)
            report_mismatch($sformatf("energy %0d, expected %0d", rsp.energy, want.energy));
          if (rsp.last_of_gather !== want.last_of_gather)
            report_mismatch($sformatf("last_of_gather %b, expected %b",
                                      rsp.last_of_gather, want.last_of_gather));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %b, expected %b", rsp.status, want.status));
        end
      end
    end
    outstanding = readout_q.size();
  end

endmodule

### test/tb_windowed_energy_gather.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_windowed_energy_gather - testbench top for the windowed energy gather
// Drives whole gathers of samples and their read-out under several register
// settings and idling patterns; the checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_windowed_energy_gather;
  import weg_pkg::*;

  localparam int STALL_LIMIT = 100000;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_ready;
  weg_req_t             req;
  logic                 rsp_valid;
  logic                 rsp_ready;
  weg_rsp_t             rsp;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   errors;
  int                   outstanding;

  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          long_hold_pending;
  int unsigned eff_s, eff_t, eff_w;
  int unsigned random_items;

  windowed_energy_gather u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  weg_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // response side: random idling per cycle plus an occasional long hold-off
  initial begin
    int hold_cnt;
    hold_cnt  = 0;
    rsp_ready = 0;
    forever begin
      @(negedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_ready <= 0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog: cycles with no request and no response accepted
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // idle cycles before each request, drawn per cycle
  task automatic send(logic op, logic signed [SAMPLE_BITS-1:0] smp);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 0;
      @(negedge clk);
    end
    req_valid <= 1;
    req       <= '{opcode: op, sample: smp};
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    req_valid <= 0;
    while (outstanding != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we    <= 0;
  endtask

  // all registers, written with the block idle
  task automatic setup(int unsigned s, int unsigned t, int unsigned wl, int unsigned ws,
                       int unsigned nw, bit nrm, bit avg);
    int unsigned cap;
    wait_drain();
    write_reg(REG_SAMPLES, s);
    write_reg(REG_TRACES, t);
    write_reg(REG_WLEN, wl);
    write_reg(REG_WSTEP, ws);
    write_reg(REG_WINDOWS, nw);
    write_reg(REG_NORM, nrm);
    write_reg(REG_AVERAGE, avg);
    eff_s = (s < 1) ? 1 : ((s > 1024) ? 1024 : s);
    eff_w = (nw < 1) ? 1 : nw;
    cap   = 4096 / eff_w;
    if (cap > 64) cap = 64;
    if (cap < 1) cap = 1;
    eff_t = (t < 1) ? 1 : ((t > cap) ? cap : t);
  endtask

  task automatic rand_setup();
    if ($urandom_range(9) == 0)
      setup(1, $urandom_range(65, 127), $urandom_range(0, 20),
            $urandom_range(0, 10), 1, $urandom_range(1), $urandom_range(1));
    else
      setup($urandom_range(0, 24), $urandom_range(0, 4), $urandom_range(0, 20),
            $urandom_range(0, 10), $urandom_range(0, 8), $urandom_range(1), $urandom_range(1));
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return $signed(16'($urandom_range(0, 31)) - 16'd16);
      default: return $signed(16'($urandom));
    endcase
  endfunction

  // one full gather: its samples, a few stray requests, then its read-out
  task automatic run_gather(bit hold_readout);
    int unsigned pushes, reads;
    pushes = eff_s * eff_t;
    reads  = eff_t * eff_w;
    for (int unsigned k = 0; k < pushes; k++) begin
      if ($urandom_range(19) == 0) begin
        send(OP_READ, rand_sample());
        random_items++;
      end
      send(OP_PUSH, rand_sample());
    end
    // samples offered while the gather waits to be read are dropped
    if ($urandom_range(2) == 0) repeat ($urandom_range(1, 3)) send(OP_PUSH, rand_sample());
    if (hold_readout) long_hold_pending = 1;
    for (int unsigned k = 0; k < reads; k++) send(OP_READ, rand_sample());
    if ($urandom_range(4) == 0) send(OP_READ, rand_sample());
    random_items += pushes + reads;
  endtask

  task automatic random_phase(int unsigned quota);
    int unsigned start;
    start = random_items;
    while (random_items - start < quota) begin
      rand_setup();
      run_gather(0);
    end
  endtask

  // stimulus
  initial begin
    req_valid         = 0;
    req               = '0;
    cfg_we            = 0;
    cfg_index         = '0;
    cfg_data          = '0;
    tx_idle_pct       = 0;
    rx_idle_pct       = 0;
    long_hold_pending = 0;
    random_items      = 0;
    rst               = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: read before any gather, then a small gather with signed extremes
    send(OP_READ, 16'sd0);
    setup(4, 2, 3, 2, 3, 1, 1);
    send(OP_PUSH, -16'sd32768);
    send(OP_PUSH, 16'sd32767);
    send(OP_PUSH, 16'sd0);
    send(OP_PUSH, -16'sd1);
    send(OP_READ, 16'sd0);
    send(OP_PUSH, 16'sd1);
    send(OP_PUSH, -16'sd2);
    send(OP_PUSH, 16'sd300);
    send(OP_PUSH, -16'sd32767);
    send(OP_PUSH, 16'sd5);
    repeat (6) send(OP_READ, 16'sd0);
    send(OP_READ, -16'sd1);

    // sender idles lightly, receiver heavily
    tx_idle_pct = 12;
    rx_idle_pct = 69;
    random_phase(100);
    // windows longer than the trace, later windows starting past its end
    setup(20, 1, 2047, 2047, 4, 0, 1);
    run_gather(0);

    tx_idle_pct = 69;
    rx_idle_pct = 12;
    random_phase(100);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    setup(6, 3, 4, 3, 5, 1, 0);
    run_gather(1);
    random_phase(100);
    // all-zero registers clamp to one, and step 0 elsewhere
    setup(0, 0, 0, 1, 0, 1, 0);
    run_gather(0);
    setup(8, 3, 2047, 0, 2, 0, 1);
    run_gather(0);

    @(negedge clk);
    req_valid <= 0;
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### windowed_energy_gather.f
rtl/weg_pkg.sv
rtl/weg_div.sv
rtl/windowed_energy_gather.sv
test/weg_checker.sv
test/tb_windowed_energy_gather.sv
